### sv/xrd_pkg.sv
// ----------------------------------------------------------------------------
// xrd_pkg: shared types and constants of the xoshiro random draw block
// Operation codes, payload structs and the splitmix64 mixing constants.
// ----------------------------------------------------------------------------
package xrd_pkg;

  // Operation selector carried in the func field of an input word.
  typedef enum logic [1:0] {
    FUNC_RESEED = 2'd0,
    FUNC_RAW    = 2'd1,
    FUNC_RANGE  = 2'd2,
    FUNC_NONE   = 2'd3
  } xrd_func_e;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned ROT_OUT   = 23;
  localparam int unsigned SHIFT_T   = 17;
  localparam int unsigned ROT_W3    = 45;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        seed;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } xrd_in_t;

  typedef struct packed {
    logic [63:0]        raw;
    logic signed [31:0] pick;
    logic [31:0]        draws;
  } xrd_out_t;

endpackage

### sv/xrd_if.sv
// ----------------------------------------------------------------------------
// xrd_if: valid/ready channels of the xoshiro random draw block
// One interface for the request channel and one for the result channel.
// ----------------------------------------------------------------------------
interface xrd_in_if;
  import xrd_pkg::*;
  logic    valid;
  logic    ready;
  xrd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xrd_out_if;
  import xrd_pkg::*;
  logic     valid;
  logic     ready;
  xrd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/xoshiro_random_draw.sv
// ----------------------------------------------------------------------------
// xoshiro_random_draw: xoshiro256++ generator with reseed and range draws
// A small sequencer drives one shared 32x32 multiplier for the splitmix64
// seed expansion and for the exact scaling of range draws.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Fields                     | Handshake
//  --------+-----+----------------------------+------------------
//  in_i    | in  | func, seed, low, high      | valid/ready
//  out_o   | out | raw, pick, draws           | valid/ready
//
// An ignored selector or an empty range is answered from the idle state; raw
// and range draws pass the draw state, range draws then the scaling states,
// and a reseed runs the splitmix64 expansion. The reseed is bounded by the
// shared multiplier: each splitmix64 step needs two 64-bit products of 3
// passes each. After reset the block expands seed zero and holds in_i.ready
// low meanwhile. The result register lets a new word be accepted in the
// same cycle that the waiting result is taken; a stalled result blocks input.
module xoshiro_random_draw (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrd_in_if.sink    in_i,
  xrd_out_if.source out_o
);
  import xrd_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MIX_ADD  = 4'd1;
  localparam logic [3:0] S_MUL0     = 4'd2;
  localparam logic [3:0] S_MUL1     = 4'd3;
  localparam logic [3:0] S_MUL2     = 4'd4;
  localparam logic [3:0] S_MIX_POST = 4'd5;
  localparam logic [3:0] S_DRAW     = 4'd6;
  localparam logic [3:0] S_SC0      = 4'd7;
  localparam logic [3:0] S_SC1      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam int unsigned IdxW = $clog2(NUM_WORDS);

  // Control state.
  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] step_q, step_d;
  logic            phase_q, phase_d;
  logic            boot_q, boot_d;
  logic [63:0]     seed_acc_q, seed_acc_d;
  logic [63:0]     count_q, count_d;
  logic            out_valid_q, out_valid_d;

  // Datapath registers.
  logic [63:0]        words_q [NUM_WORDS];
  logic [63:0]        words_d [NUM_WORDS];
  logic [63:0]        x_q, x_d;
  logic [63:0]        acc_q, acc_d;
  logic [63:0]        raw_q, raw_d;
  logic [31:0]        span_q, span_d;
  logic signed [31:0] low_q, low_d;
  logic [1:0]         op_q, op_d;
  xrd_out_t           out_q, out_d;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] mix_const;

  // Generator step, purely XOR, shift and add.
  logic [63:0] adv_out, adv_sum, n0, n1, n2, n3, t_w;

  logic        in_fire, out_free, range_empty;
  logic [63:0] mix_sum, mix_in;
  logic [32:0] span_wide;

  assign mix_const = phase_q ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    mul_a = x_q[31:0];
    mul_b = mix_const[31:0];
    case (state_q)
      S_MUL1: begin
        mul_a = x_q[63:32];
      end
      S_MUL2: begin
        mul_b = mix_const[63:32];
      end
      S_SC0: begin
        mul_b = span_q;
      end
      S_SC1: begin
        mul_a = x_q[63:32];
        mul_b = span_q;
      end
      default: begin
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // xoshiro256++ output and state transition.
  assign adv_sum = words_q[0] + words_q[3];
  assign adv_out = {adv_sum[63-ROT_OUT:0], adv_sum[63:64-ROT_OUT]} + words_q[0];
  assign t_w     = words_q[1] << SHIFT_T;
  assign n2      = words_q[2] ^ words_q[0];
  assign n3      = words_q[3] ^ words_q[1];
  assign n1      = words_q[1] ^ n2;
  assign n0      = words_q[0] ^ n3;

  assign mix_sum = seed_acc_q + GOLDEN_STEP;
  assign mix_in  = mix_sum ^ (mix_sum >> 30);

  // Range bounds: the span is positive and below 2^32 whenever low < high.
  assign range_empty = (in_i.data.low >= in_i.data.high);
  assign span_wide   = {in_i.data.high[31], in_i.data.high} -
                       {in_i.data.low[31], in_i.data.low};

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    boot_d      = boot_q;
    seed_acc_d  = seed_acc_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    words_d     = words_q;
    x_d         = x_q;
    acc_d       = acc_q;
    raw_d       = raw_q;
    span_d      = span_q;
    low_d       = low_q;
    op_d        = op_q;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = in_i.data.func;
          low_d  = in_i.data.low;
          span_d = span_wide[31:0];
          case (in_i.data.func)
            FUNC_RESEED: begin
              seed_acc_d = in_i.data.seed;
              step_d     = '0;
              phase_d    = 1'b0;
              count_d    = '0;
              state_d    = S_MIX_ADD;
            end
            FUNC_RAW: begin
              state_d = S_DRAW;
            end
            FUNC_RANGE: begin
              if (range_empty) begin
                // Nothing is drawn; the lower bound is returned as is.
                out_d.raw   = '0;
                out_d.pick  = in_i.data.low;
                out_d.draws = count_q[31:0];
                out_valid_d = 1'b1;
              end else begin
                state_d = S_DRAW;
              end
            end
            default: begin
              out_d.raw   = '0;
              out_d.pick  = '0;
              out_d.draws = count_q[31:0];
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_MIX_ADD: begin
        seed_acc_d = mix_sum;
        x_d        = mix_in;
        state_d    = S_MUL0;
      end
      S_MUL0: begin
        acc_d   = prod;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = S_MIX_POST;
      end
      S_MIX_POST: begin
        if (!phase_q) begin
          x_d     = acc_q ^ (acc_q >> 27);
          phase_d = 1'b1;
          state_d = S_MUL0;
        end else begin
          words_d[step_q] = acc_q ^ (acc_q >> 31);
          phase_d         = 1'b0;
          if (step_q == IdxW'(NUM_WORDS - 1)) begin
            boot_d  = 1'b0;
            state_d = boot_q ? S_IDLE : S_DONE;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = S_MIX_ADD;
          end
        end
      end
      S_DRAW: begin
        raw_d      = adv_out;
        words_d[0] = n0;
        words_d[1] = n1;
        words_d[2] = n2 ^ t_w;
        words_d[3] = {n3[63-ROT_W3:0], n3[63:64-ROT_W3]};
        count_d    = count_q + 64'd1;
        x_d        = {11'd0, adv_out[63:11]};
        state_d    = (op_q == FUNC_RANGE) ? S_SC0 : S_DONE;
      end
      S_SC0: begin
        acc_d   = prod;
        state_d = S_SC1;
      end
      S_SC1: begin
        // High partial product plus the carry-in of the low one.
        acc_d   = prod + {32'd0, acc_q[63:32]};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_d.raw   = (op_q == FUNC_RESEED) ? 64'd0 : raw_q;
          out_d.pick  = (op_q == FUNC_RANGE) ? (low_q + $signed(acc_q[52:21])) : 32'sd0;
          out_d.draws = count_q[31:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // After reset the sequencer expands seed zero before taking any word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_MIX_ADD;
      step_q      <= '0;
      phase_q     <= 1'b0;
      boot_q      <= 1'b1;
      seed_acc_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      boot_q      <= boot_d;
      seed_acc_q  <= seed_acc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
    x_q     <= x_d;
    acc_q   <= acc_d;
    raw_q   <= raw_d;
    span_q  <= span_d;
    low_q   <= low_d;
    op_q    <= op_d;
    out_q   <= out_d;
  end

endmodule

### sv/xrd_checker.sv
// ----------------------------------------------------------------------------
// xrd_checker: port-level assertions for the xoshiro random draw block
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module xrd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input xrd_pkg::xrd_in_t   in_data_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input xrd_pkg::xrd_out_t  out_data_i
);
  import xrd_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A result that is not taken keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // A new word is only taken when the result slot can be refilled.
  a_in_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_ready_i)
    else $error("input accepted while result stalled");

  // An ignored selector answers in the next cycle with no draw.
  a_none_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.func == FUNC_NONE) |=>
      out_valid_i && (out_data_i.raw == 64'd0) && (out_data_i.pick == 32'sd0))
    else $error("ignored selector gave a wrong result");

  // An empty range returns its lower bound in the next cycle.
  a_empty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.func == FUNC_RANGE) && (in_data_i.low >= in_data_i.high) |=>
      out_valid_i && (out_data_i.raw == 64'd0) &&
      (out_data_i.pick == $past(in_data_i.low)))
    else $error("empty range gave a wrong result");

endmodule

bind xoshiro_random_draw xrd_checker u_xrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

### tb/sv/tb_xoshiro_random_draw.sv
// ----------------------------------------------------------------------------
// tb_xoshiro_random_draw: self-checking regression of the xoshiro random draw
// Streams directed and random request words through the block with random
// gaps on the request side and random stalls on the result side. A generator
// kept inside the bench predicts every result word, which is compared field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_xoshiro_random_draw;
  import xrd_pkg::*;

  // Random request words that do something (unused selectors do not count).
  localparam int unsigned RANDOM_WORDS  = 985;
  // The last words of the run go through with neither gaps nor stalls.
  localparam int unsigned TAIL_WORDS    = 120;
  // Extra cycles after the last result: longer than a reseed takes.
  localparam int unsigned SETTLE_CYCLES = 60;
  // Every so many queued words the sender waits for the block to drain.
  localparam int unsigned DRAIN_EVERY   = 300;
  localparam int unsigned REPORT_LIMIT  = 10;

  localparam logic signed [31:0] LOW_END  = 32'sh8000_0000;
  localparam logic signed [31:0] HIGH_END = 32'sh7fff_ffff;

  // One queued request word. When after_drain is set, the sender holds the
  // word back until every result word already owed has come out.
  typedef struct {
    xrd_in_t word;
    bit      after_drain;
  } request_slot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  xrd_in_if  req_ch ();
  xrd_out_if res_ch ();

  xoshiro_random_draw DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  request_slot_t request_words[$];
  xrd_out_t      expected_results[$];

  // Generator state as the bench predicts it.
  logic [63:0] gen_state [NUM_WORDS];
  logic [63:0] draw_total;

  int unsigned total_words;
  int unsigned words_driven;
  int unsigned words_taken;
  int unsigned results_checked;
  int unsigned miss_count;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned n_reseed, n_raw, n_range, n_empty, n_unused;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Generator model
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

  // One splitmix64 step: bumps the accumulator and returns the mixed value.
  function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
    logic [63:0] z;
    acc = acc + GOLDEN_STEP;
    z   = acc;
    z   = (z ^ (z >> 30)) * MIX_MUL_A;
    z   = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic void load_seed(logic [63:0] seed);
    logic [63:0] acc;
    int          i;
    acc = seed;
    for (i = 0; i < NUM_WORDS; i++) begin
      gen_state[i] = splitmix_next(acc);
    end
    draw_total = '0;
  endfunction

  // xoshiro256++ output and state update; every call counts as one draw.
  function automatic logic [63:0] xoshiro_step();
    logic [63:0] drawn;
    logic [63:0] t;
    drawn = rotl64(gen_state[0] + gen_state[3], ROT_OUT) + gen_state[0];
    t     = gen_state[1] << SHIFT_T;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ t;
    gen_state[3] = rotl64(gen_state[3], ROT_W3);
    draw_total   = draw_total + 64'd1;
    return drawn;
  endfunction

  // Works out the result word of one accepted request and moves the model on.
  // A range draw scales the top 53 bits of the draw by the span with an exact
  // 85-bit product; the span is below 2^32, so the quotient fits in 32 bits.
  function automatic xrd_out_t predict_draw(xrd_in_t w);
    xrd_out_t           r;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic        [32:0] span;
    logic        [84:0] prod;
    r  = '0;
    lo = w.low;
    hi = w.high;
    case (w.func)
      FUNC_RESEED: begin
        load_seed(w.seed);
        n_reseed++;
      end
      FUNC_RAW: begin
        r.raw = xoshiro_step();
        n_raw++;
      end
      FUNC_RANGE: begin
        n_range++;
        if (lo >= hi) begin
          // Empty bounds: nothing is drawn and the low bound comes back.
          r.pick = lo;
          n_empty++;
        end else begin
          span   = {hi[31], hi} - {lo[31], lo};
          r.raw  = xoshiro_step();
          prod   = {32'd0, r.raw[63:11]} * {53'd0, span[31:0]};
          r.pick = lo + prod[84:53];
        end
      end
      default: begin
        // Unused selector: the state is left alone.
        n_unused++;
      end
    endcase
    r.draws = draw_total[31:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers for stimulus and checking
  // --------------------------------------------------------------------------

  function automatic void queue_word(xrd_func_e f, logic [63:0] seed,
                                     logic signed [31:0] lo, logic signed [31:0] hi,
                                     bit drain = 1'b0);
    request_slot_t s;
    s.word.func   = f;
    s.word.seed   = seed;
    s.word.low    = lo;
    s.word.high   = hi;
    s.after_drain = drain;
    request_words.push_back(s);
  endfunction

  // True once only the last stretch of the run is left; both sides then stop
  // idling. It depends on accepted words only, so both sides agree on it.
  function automatic bit in_tail();
    return (total_words - words_taken) < TAIL_WORDS;
  endfunction

  function automatic void note_miss(string what, logic [63:0] want_v, logic [63:0] got_v);
    miss_count++;
    if (miss_count <= REPORT_LIMIT) begin
      $display("[%0t] %s wrong after %0d checked words: expected %h, got %h",
               $time, what, results_checked, want_v, got_v);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: changes the channel at the falling edge only. A word that
  // has not been accepted yet stays on the channel unchanged.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && words_taken != words_driven) begin
      // The block has not taken the current word yet; keep holding it.
    end else if (gap_left != 0 && !in_tail()) begin
      gap_left--;
      req_ch.valid <= 1'b0;
    end else if (request_words.size() == 0 ||
                 (request_words[0].after_drain && expected_results.size() != 0)) begin
      // Nothing left to send, or waiting for the block to run empty.
      req_ch.valid <= 1'b0;
    end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
      // Start an idle burst, this cycle included; gap_left holds the rest of it.
      gap_left = $urandom_range(0, 15);
      req_ch.valid <= 1'b0;
    end else begin
      req_ch.data  <= request_words[0].word;
      req_ch.valid <= 1'b1;
      void'(request_words.pop_front());
      words_driven++;
    end
  end

  // Result sink: stalls in bursts, never during the tail; stall_left holds the rest.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0 && !in_tail()) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The result word is
  // checked before the request of the same edge is predicted, since a result
  // can never belong to a request accepted at that very edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    xrd_out_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_miss("unexpected result word, raw", 64'd0, res_ch.data.raw);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (res_ch.data.raw !== want.raw) begin
            note_miss("raw", want.raw, res_ch.data.raw);
          end
          if (res_ch.data.pick !== want.pick) begin
            note_miss("pick", {32'd0, want.pick}, {32'd0, res_ch.data.pick});
          end
          if (res_ch.data.draws !== want.draws) begin
            note_miss("draws", {32'd0, want.draws}, {32'd0, res_ch.data.draws});
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_draw(req_ch.data));
        words_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned        useful;
    int unsigned        roll;
    xrd_func_e          op;
    logic        [63:0] seed_v;
    logic signed [31:0] lo_v;
    logic signed [31:0] hi_v;

    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;

    // After reset the generator holds the expansion of seed zero.
    load_seed(64'd0);

    // Directed words. The first ones run on the state left by reset.
    queue_word(FUNC_NONE, {$urandom(), $urandom()}, $urandom(), $urandom());
    queue_word(FUNC_RAW, '0, '0, '0);
    queue_word(FUNC_RAW, '1, '1, '1);
    // Widest span, spans of one at both ends of the range, half spans.
    queue_word(FUNC_RANGE, '0, LOW_END, HIGH_END);
    queue_word(FUNC_RANGE, '0, 32'sd0, 32'sd1);
    queue_word(FUNC_RANGE, '0, HIGH_END - 32'sd1, HIGH_END);
    queue_word(FUNC_RANGE, '0, LOW_END, LOW_END + 32'sd1);
    queue_word(FUNC_RANGE, '0, LOW_END, 32'sd0);
    queue_word(FUNC_RANGE, '0, 32'sd0, HIGH_END);
    // Empty bounds: equal, reversed at the extremes, reversed near zero.
    queue_word(FUNC_RANGE, '0, 32'sd5, 32'sd5);
    queue_word(FUNC_RANGE, '0, HIGH_END, LOW_END);
    queue_word(FUNC_RANGE, '0, -32'sd1, -32'sd2);
    // Reseeds with extreme seeds, each followed by draws.
    queue_word(FUNC_RESEED, 64'd0, '0, '0);
    queue_word(FUNC_RAW, '0, '0, '0);
    queue_word(FUNC_RESEED, '1, '1, '1);
    queue_word(FUNC_RAW, '0, '0, '0);
    queue_word(FUNC_RANGE, '0, -32'sd1000, 32'sd1000);
    queue_word(FUNC_RESEED, 64'h8000_0000_0000_0000, '0, '0);
    queue_word(FUNC_RANGE, '0, LOW_END, HIGH_END);
    queue_word(FUNC_RESEED, 64'd1, '0, '0);
    queue_word(FUNC_NONE, '0, '0, '0);
    queue_word(FUNC_RAW, '0, '0, '0);
    queue_word(FUNC_NONE, '1, '1, '1);
    queue_word(FUNC_RAW, '0, '0, '0);

    // Random words: mostly draws, with reseeds sprinkled in. Fields that the
    // operation does not use still carry random values.
    useful = 0;
    while (useful < RANDOM_WORDS) begin
      roll   = $urandom_range(0, 99);
      seed_v = {$urandom(), $urandom()};
      lo_v   = $urandom();
      hi_v   = $urandom();
      if (roll < 8) begin
        op = FUNC_RESEED;
      end else if (roll < 40) begin
        op = FUNC_RAW;
      end else if (roll < 96) begin
        op = FUNC_RANGE;
      end else begin
        op = FUNC_NONE;
      end
      if (op == FUNC_RESEED && $urandom_range(0, 15) == 0) begin
        seed_v = $urandom_range(0, 1) ? 64'd0 : '1;
      end
      if (op == FUNC_RANGE) begin
        case ($urandom_range(0, 4))
          0, 1: begin
            // Small spans; a wrap past the top gives empty bounds.
            hi_v = lo_v + $urandom_range(1, 1000);
          end
          2: begin
            // Fully random bounds, empty about half of the time.
          end
          3: begin
            hi_v = $urandom_range(0, 1) ? lo_v : lo_v - $urandom_range(1, 50);
          end
          default: begin
            lo_v = LOW_END + $urandom_range(0, 255);
            hi_v = HIGH_END - $urandom_range(0, 255);
          end
        endcase
      end
      if (op != FUNC_NONE) begin
        useful++;
      end
      queue_word(op, seed_v, lo_v, hi_v, (request_words.size() % DRAIN_EVERY) == 0);
    end
    total_words = request_words.size();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken != total_words || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    // Let a stray extra result word show up if the block produces one.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d reseeds, %0d raw draws, %0d range draws (%0d with empty bounds)",
             n_reseed, n_raw, n_range, n_empty);
    $display("and %0d unused selectors; %0d result words checked, %0d mismatches.",
             n_unused, results_checked, miss_count);
    if (miss_count == 0) begin
      $display("xoshiro_random_draw regression: pass");
    end else begin
      $display("xoshiro_random_draw regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #4_000_000;
    $display("Timed out with %0d words accepted and %0d result words outstanding.",
             words_taken, expected_results.size());
    $display("xoshiro_random_draw regression: fail");
    $finish;
  end

endmodule

### files.f
sv/xrd_pkg.sv
sv/xrd_if.sv
sv/xoshiro_random_draw.sv
sv/xrd_checker.sv
tb/sv/tb_xoshiro_random_draw.sv
